### rtl/fmbq_pkg.sv
`timescale 1ns / 1ps

package fmbq_pkg;

  // Field widths of the command and result beats
  localparam int KIND_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - STATUS_W;

  // Command codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_MIDDLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_MIDDLE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP_BACK    = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // End operations applied to one half of the queue
  typedef struct packed {
    logic ins_front;
    logic ins_back;
    logic del_front;
    logic del_back;
  } ring_op_t;

endpackage

### rtl/front_middle_back_queue.sv
`timescale 1ns / 1ps

// Ordered queue of up to DEPTH words with push and pop at the front, the
// middle and the back. Each command beat gives exactly one result beat with
// the popped word (zero unless a pop succeeded) and a status: done, pop on
// empty, or push on full (the word is dropped). A middle push inserts at
// position floor(n/2) and a middle pop removes position floor((n-1)/2).
// Throughput is one command per clock unless the result port stalls; an
// accepted command is registered, then executes and its result is registered.
// The queue is kept as two circular halves, each in its own RAM with one
// write and one registered read port, the front half holding floor(n/2)
// words; every command touches only the ends of the halves, and the end
// words for the next command are fetched while the current one executes.
// No clearing pass is needed after reset.
module front_middle_back_queue import fmbq_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // [2:0] kind, [34:3] push_value
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] popped_value, [33:32] status
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready
);

  localparam int SW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int CAP_F = DEPTH / 2;
  localparam int CAP_B = DEPTH - DEPTH / 2;
  localparam int FCW   = $clog2(CAP_F + 1);
  localparam int BCW   = $clog2(CAP_B + 1);
  localparam int NW    = $clog2(DEPTH + 1);

  logic                in_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [SW-1:0]       value_q;
  logic                out_valid_q;
  logic [VALUE_W-1:0]  popped_q;
  logic [STATUS_W-1:0] status_q;

  logic                exec, accept;
  logic [KIND_W-1:0]   next_kind;
  logic [FCW-1:0]      f_cnt;
  logic [BCW-1:0]      b_cnt;
  logic [NW-1:0]       n;
  logic                odd, empty, full;
  ring_op_t            f_op, b_op;
  logic [SW-1:0]       f_wdata, b_wdata, f_rdata, b_rdata, pop_data;
  logic [STATUS_W-1:0] status_d;

  // Handshake: execute when the result register is free or being drained
  assign exec          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || exec;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign next_kind     = s_axis_tready ? s_axis_tdata[KIND_W-1:0] : kind_q;

  // Occupancy from both halves
  assign n     = NW'(f_cnt) + NW'(b_cnt);
  assign odd   = n[0];
  assign empty = (n == '0);
  assign full  = (n == NW'(DEPTH));

  // Decode the command into end operations on the two halves
  always_comb begin
    f_op     = '0;
    b_op     = '0;
    f_wdata  = value_q;
    b_wdata  = value_q;
    pop_data = '0;
    status_d = STATUS_DONE;
    unique case (kind_q)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else if (empty) begin
          b_op.ins_front = 1'b1;
        end else if (!odd) begin
          f_op.ins_front = 1'b1;
          f_op.del_back  = 1'b1;
          b_op.ins_front = 1'b1;
          b_wdata        = f_rdata;
        end else begin
          f_op.ins_front = 1'b1;
        end
      end
      KIND_PUSH_MIDDLE: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else if (!odd) begin
          b_op.ins_front = 1'b1;
        end else begin
          f_op.ins_back = 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_FULL;
        end else begin
          b_op.ins_back = 1'b1;
          if (odd) begin
            b_op.del_front = 1'b1;
            f_op.ins_back  = 1'b1;
            f_wdata        = b_rdata;
          end
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else if (n == NW'(1)) begin
          b_op.del_front = 1'b1;
          pop_data       = b_rdata;
        end else begin
          f_op.del_front = 1'b1;
          pop_data       = f_rdata;
          if (odd) begin
            b_op.del_front = 1'b1;
            f_op.ins_back  = 1'b1;
            f_wdata        = b_rdata;
          end
        end
      end
      KIND_POP_MIDDLE: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else if (odd) begin
          b_op.del_front = 1'b1;
          pop_data       = b_rdata;
        end else begin
          f_op.del_back = 1'b1;
          pop_data      = f_rdata;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_d = STATUS_EMPTY;
        end else begin
          b_op.del_back = 1'b1;
          pop_data      = b_rdata;
          if (!odd) begin
            f_op.del_back  = 1'b1;
            b_op.ins_front = 1'b1;
            b_wdata        = f_rdata;
          end
        end
      end
      default: begin
        status_d = STATUS_DONE;
      end
    endcase
    if (!exec) begin
      f_op = '0;
      b_op = '0;
    end
  end

  // Front half: the next command needs its front only for a front pop
  fmbq_ring #(
    .WIDTH (SW),
    .CAP   (CAP_F)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (f_op),
    .wdata_i   (f_wdata),
    .rd_back_i (next_kind != KIND_POP_FRONT),
    .rd_data_o (f_rdata),
    .cnt_o     (f_cnt)
  );

  // Back half: the next command needs its back only for a back pop
  fmbq_ring #(
    .WIDTH (SW),
    .CAP   (CAP_B)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (b_op),
    .wdata_i   (b_wdata),
    .rd_back_i (next_kind == KIND_POP_BACK),
    .rd_data_o (b_rdata),
    .cnt_o     (b_cnt)
  );

  // Command and result valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (exec) begin
        in_valid_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the command beat and the result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= s_axis_tdata[KIND_W-1:0];
      value_q <= s_axis_tdata[KIND_W +: SW];
    end
    if (exec) begin
      popped_q <= VALUE_W'(pop_data);
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, status_q, popped_q};

  // The front half holds floor(n/2) words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (BCW'(f_cnt) == b_cnt) || (BCW'(f_cnt) + BCW'(1) == b_cnt))
    else $error("queue halves out of balance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    n <= NW'(DEPTH))
    else $error("occupancy above depth");

  // A successful push grows the queue by one word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (status_d == STATUS_DONE) &&
    (kind_q == KIND_PUSH_FRONT || kind_q == KIND_PUSH_MIDDLE || kind_q == KIND_PUSH_BACK)
    |=> n == $past(n) + NW'(1))
    else $error("push did not add a word");

  // Input stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("command port stalled without cause");

endmodule

### rtl/fmbq_ram.sv
`timescale 1ns / 1ps

module fmbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/fmbq_ring.sv
`timescale 1ns / 1ps

// Circular deque holding one half of the queue. The read port always
// fetches one end of the deque as it stands after this cycle's operation,
// so the end word is ready when the next command executes.
module fmbq_ring import fmbq_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int CAP = 512,
  localparam int PW = (CAP > 1) ? $clog2(CAP) : 1,
  localparam int CW = $clog2(CAP + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ring_op_t         op_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_back_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic [CW-1:0]    cnt_o
);

  localparam int SUMW = ((PW > CW) ? PW : CW) + 1;
  localparam logic [PW-1:0] LAST_IDX = PW'(CAP - 1);

  logic [PW-1:0]    head_q, head_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [PW-1:0]    head_m1, head_p1, tail_idx, back_idx;
  logic [PW-1:0]    waddr, raddr;
  logic             we;
  logic             byp_d, byp_q;
  logic [WIDTH-1:0] byp_data_q;
  logic [WIDTH-1:0] ram_rdata;

  // Index a + b modulo CAP, with a below CAP and b at most CAP
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
    logic [SUMW-1:0] s;
    s = SUMW'(a) + SUMW'(b);
    if (s >= SUMW'(CAP)) begin
      s = s - SUMW'(CAP);
    end
    return s[PW-1:0];
  endfunction

  // Neighbor indices of the head and the free slot past the tail
  assign head_m1  = (head_q == '0) ? LAST_IDX : head_q - PW'(1);
  assign head_p1  = (head_q == LAST_IDX) ? '0 : head_q + PW'(1);
  assign tail_idx = wrap_add(head_q, cnt_q);

  // Write the pushed word at the chosen end
  assign we    = op_i.ins_front | op_i.ins_back;
  assign waddr = op_i.ins_front ? head_m1 : tail_idx;

  // Advance head and count
  always_comb begin
    head_d = head_q;
    if (op_i.del_front) begin
      head_d = head_p1;
    end else if (op_i.ins_front) begin
      head_d = head_m1;
    end
    cnt_d = cnt_q + CW'(we) - CW'(op_i.del_front | op_i.del_back);
  end

  // Fetch the requested end of the updated deque
  assign back_idx = (cnt_d == '0) ? head_d : wrap_add(head_d, cnt_d - CW'(1));
  assign raddr    = rd_back_i ? back_idx : head_d;
  assign byp_d    = we && (waddr == raddr);

  fmbq_ram #(
    .WIDTH (WIDTH),
    .DEPTH (CAP)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata_i),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      byp_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      byp_q  <= byp_d;
    end
  end

  // Hold the word written to the fetched slot in the same cycle
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata_i;
  end

  assign rd_data_o = byp_q ? byp_data_q : ram_rdata;
  assign cnt_o     = cnt_q;

endmodule
